// ===== hdl/mfir_pkg.sv =====
// ----------------------------------------------------------------------------
// Multichannel FIR package
// Shared constants, types and arithmetic helpers for the multichannel FIR core.
// ----------------------------------------------------------------------------
package mfir_pkg;

  localparam int TAPS       = 16;
  localparam int CHANNELS   = 2;
  localparam int HIST       = TAPS - 1;
  localparam int COEF_WORDS = 4;
  localparam int COEF_MAX   = 16;
  localparam int LIM        = (TAPS < COEF_MAX) ? TAPS : COEF_MAX;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW         = $clog2(TAPS);
  localparam int AW         = 32 + $clog2(TAPS);
  localparam int CFG_IW     = 3;
  localparam int SW         = 16;

  typedef enum logic [CFG_IW-1:0] {
    REG_COEFF_WORD_0 = 3'd0,
    REG_COEFF_WORD_1 = 3'd1,
    REG_COEFF_WORD_2 = 3'd2,
    REG_COEFF_WORD_3 = 3'd3,
    REG_TAP_COUNT    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            en;
    logic            insert;
    logic [CH_W-1:0] sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctrl_t;

  typedef logic [COEF_WORDS-1:0][63:0] coef_bank_t;

  // Coefficient of tap k; taps past the sixteenth read as zero.
  function automatic logic signed [SW-1:0] tap_coef(input coef_bank_t bank,
                                                    input logic [KW-1:0] k);
    logic [7:0] kk;
    kk = 8'(k);
    if (kk >= 8'(COEF_MAX)) begin
      return '0;
    end
    return $signed(bank[kk[3:2]][{kk[1:0], 4'b0000} +: SW]);
  endfunction

  // Filter length in use: zero acts as one, large values clamp to LIM.
  function automatic logic [7:0] eff_len(input logic [4:0] tc);
    logic [7:0] l;
    l = 8'(tc);
    if (l < 8'd1) begin
      l = 8'd1;
    end
    if (l > 8'(LIM)) begin
      l = 8'(LIM);
    end
    return l;
  endfunction

  // Round half up from Q6.30 and saturate to Q1.15.
  function automatic logic signed [SW-1:0] round_sat(input logic signed [AW-1:0] acc);
    logic signed [AW:0]    b;
    logic signed [AW-15:0] y;
    b = {acc[AW-1], acc} + (AW+1)'(16384);
    y = b[AW:15];
    if (y > $signed((AW-14)'(32767))) begin
      return 16'sh7fff;
    end
    if (y < -$signed((AW-14)'(32768))) begin
      return 16'sh8000;
    end
    return y[SW-1:0];
  endfunction

endpackage

// ===== hdl/mfir_cell.sv =====
// ----------------------------------------------------------------------------
// Multichannel FIR delay cell
// One position of every channel's delay line; rotates or shifts with neighbors.
// ----------------------------------------------------------------------------
module mfir_cell
  import mfir_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mfir_pkg::cell_ctrl_t      ctrl_i,
  input  logic signed [mfir_pkg::SW-1:0] prev_i,
  input  logic signed [mfir_pkg::SW-1:0] next_i,
  output logic signed [mfir_pkg::SW-1:0] data_o
);

  logic signed [SW-1:0] line_q [CHANNELS];
  logic signed [SW-1:0] line_d [CHANNELS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      line_d[c] = line_q[c];
    end
    if (ctrl_i.en) begin
      line_d[ctrl_i.sel] = ctrl_i.insert ? prev_i : next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        line_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        line_q[c] <= line_d[c];
      end
    end
  end

  assign data_o = line_q[ctrl_i.sel];

endmodule

// ===== hdl/mfir_mac.sv =====
// ----------------------------------------------------------------------------
// Multichannel FIR multiply-accumulate unit
// Registered 16x16 product feeding a wide accumulator with rounding output.
// ----------------------------------------------------------------------------
module mfir_mac
  import mfir_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mfir_pkg::mac_ctrl_t            ctrl_i,
  input  logic signed [mfir_pkg::SW-1:0] sample_i,
  input  logic signed [mfir_pkg::SW-1:0] coef_i,
  output logic signed [mfir_pkg::SW-1:0] result_o
);

  logic signed [2*SW-1:0] prod_q;
  logic                   prod_v_q;
  logic signed [AW-1:0]   acc_q;
  logic signed [AW-1:0]   acc_d;

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * coef_i;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + AW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.mul_en;
      acc_q    <= acc_d;
    end
  end

  assign result_o = round_sat(acc_q);

endmodule

// ===== hdl/multichannel_fir_filter_core.sv =====
// ----------------------------------------------------------------------------
// Multichannel FIR filter core
// An input beat passes an accept step, TAPS MAC steps, a flush and a round
// step. A new beat is taken only back in idle, once the output register is
// free, as the single shared multiplier visits every tap of the delay line.
// Reset clears all delay lines, the coefficients to zero and tap_count to 16.
// ----------------------------------------------------------------------------
module multichannel_fir_filter_core
  import mfir_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [15:0] sample_in
  input  logic [0:0]                      s_axis_tuser,  // [0] channel
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [15:0] filtered
  output logic [0:0]                      m_axis_tuser,  // [0] channel_out
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [mfir_pkg::CFG_IW-1:0]     cfg_idx_i,
  input  logic [63:0]                     cfg_data_i
);

  // Configuration registers.
  coef_bank_t coef_q;
  logic [4:0] tap_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q      <= '0;
      tap_count_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COEFF_WORD_0: coef_q[0] <= cfg_data_i;
        REG_COEFF_WORD_1: coef_q[1] <= cfg_data_i;
        REG_COEFF_WORD_2: coef_q[2] <= cfg_data_i;
        REG_COEFF_WORD_3: coef_q[3] <= cfg_data_i;
        REG_TAP_COUNT:    tap_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer state. The tap counter walks k = 0 .. TAPS-1; step 0 uses the new
  // sample and every later step reads the head cell while the selected line
  // rotates by one, so after HIST rotations the line is back where it started.
  state_e               state_q, state_d;
  logic [KW-1:0]        k_q, k_d;
  logic signed [SW-1:0] x_q;
  logic                 chbit_q;
  logic [CH_W-1:0]      ch_q;
  logic                 out_valid_q;
  logic [SW-1:0]        out_data_q;
  logic                 out_ch_q;

  logic                 in_beat;
  logic                 out_free;
  logic                 last_step;
  logic                 load_out;
  cell_ctrl_t           cell_ctrl;
  mac_ctrl_t            mac_ctrl;
  logic signed [SW-1:0] mac_sample;
  logic signed [SW-1:0] mac_coef;
  logic signed [SW-1:0] mac_result;
  logic signed [SW-1:0] cell_out [HIST];

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_step = (k_q == KW'(HIST));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_MAC;
          k_d     = '0;
        end
      end
      ST_MAC: begin
        k_d = k_q + KW'(1);
        if (last_step) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    s_axis_tready   = 1'b0;
    load_out        = 1'b0;
    cell_ctrl.en     = 1'b0;
    cell_ctrl.insert = 1'b0;
    cell_ctrl.sel    = ch_q;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready  = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      ST_MAC: begin
        mac_ctrl.mul_en = 1'b1;
        cell_ctrl.en    = (k_q != '0);
      end
      ST_FLUSH: begin
        // The last product lands in the accumulator while the new sample
        // enters the head of its channel's line.
        cell_ctrl.en     = 1'b1;
        cell_ctrl.insert = 1'b1;
      end
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // Captured input beat; the channel wraps onto the available delay lines.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q     <= $signed(s_axis_tdata);
      chbit_q <= s_axis_tuser[0];
      ch_q    <= (CHANNELS > 1) ? CH_W'(s_axis_tuser[0]) : '0;
    end
  end

  // Operand selection for the shared multiplier. Taps past the active length
  // contribute zero but still rotate, keeping the whole line intact.
  assign mac_sample = (k_q == '0) ? x_q : cell_out[0];
  assign mac_coef   = (8'(k_q) < eff_len(tap_count_q)) ? tap_coef(coef_q, k_q) : '0;

  // Row of delay cells. On rotate each cell takes its successor and the head
  // wraps to the tail; on insert each cell takes its predecessor and the head
  // takes the new sample.
  for (genvar i = 0; i < HIST; i++) begin : g_cell
    logic signed [SW-1:0] prev_s;
    logic signed [SW-1:0] next_s;
    if (i == 0) begin : g_head
      assign prev_s = x_q;
    end else begin : g_body
      assign prev_s = cell_out[i-1];
    end
    if (i == HIST - 1) begin : g_tail
      assign next_s = cell_out[0];
    end else begin : g_mid
      assign next_s = cell_out[i+1];
    end
    mfir_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .prev_i (prev_s),
      .next_i (next_s),
      .data_o (cell_out[i])
    );
  end

  mfir_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (mac_sample),
    .coef_i   (mac_coef),
    .result_o (mac_result)
  );

  // Output register: holds a finished beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= mac_result;
      out_ch_q   <= chbit_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ch_q;

  // An accepted beat starts work, so the input side closes right after it.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input accepted while a sample was in flight");

  // A result can only appear when the sequencer finishes an item.
  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("output valid rose outside the finish step");

  // The line rotates back in full before the new sample is inserted.
  a_flush_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> $past(state_q == ST_MAC && last_step))
    else $error("insert step reached before all taps were visited");

endmodule
